[sv/htwd_pkg.sv]
package htwd_pkg;

	localparam int SYMBOLS    = 256;
	localparam int ROOT_INDEX = 2 * SYMBOLS - 2;
	localparam int NODE_COUNT = SYMBOLS - 1;
	localparam int NODE_AW    = $clog2(NODE_COUNT);
	localparam int IDX_W      = 9;
	localparam int SYM_W      = 8;
	localparam int BYTE_W     = 8;
	localparam int NBITS_W    = 4;
	localparam int NODE_W     = 2 * IDX_W;

	localparam logic       REQ_LOAD   = 1'b0;
	localparam logic       REQ_DECODE = 1'b1;
	localparam logic [IDX_W-1:0] ROOT_POS = IDX_W'(ROOT_INDEX);
	localparam logic [IDX_W-1:0] SYM_LIM  = IDX_W'(SYMBOLS);

	typedef struct packed {
		logic               req_type;
		logic [IDX_W-1:0]   node_index;
		logic [IDX_W-1:0]   left_child;
		logic [IDX_W-1:0]   right_child;
		logic [BYTE_W-1:0]  packed_byte;
		logic [NBITS_W-1:0] valid_bits;
	} req_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last_of_item;
	} rsp_t;

	// internal node index to node table address
	function automatic logic [NODE_AW-1:0] node_addr(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] diff;
		diff = idx - SYM_LIM;
		return diff[NODE_AW-1:0];
	endfunction

endpackage

[sv/huffman_tree_walk_decoder_core.sv]
// Huffman tree-walk decoder.
// req channel (valid/ready, req_t): a load beat (req_type = REQ_LOAD) writes the two
// children of one internal node into the node table and puts the walk back at the
// root; it gives no result. A decode beat brings a byte whose leading valid_bits
// bits (above 8 counts as 8) are walked MSB first.
// rsp channel (valid/ready, rsp_t): one beat per leaf reached, last_of_item set on
// the final symbol of a byte. A byte that reaches no leaf gives no beat and the walk
// position carries over to the next byte.
// Throughput: a decode beat holds req_ready low while its bits are walked, one bit per
// cycle unless the walk pauses on a full output, each step set by the dependent read
// of the node table RAM, then in S_FLUSH, which releases the held-back final symbol.
// A zero-bit byte leaves req_ready high. A symbol shows on rsp the cycle after the
// next leaf of its byte is walked, or, if it is the last, once S_FLUSH has loaded it.
// Reset: walk at the root, no result pending; the node table is not cleared and
// must be loaded before decoding.
// Receiver stall: one symbol waits in the output register and one more is held
// internally; the walk pauses when a further leaf is found while both are full.
module huffman_tree_walk_decoder_core
	import htwd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FLUSH
	} state_t;

	state_t              state_q;
	logic [IDX_W-1:0]    pos_q;
	logic [BYTE_W-1:0]   byte_q;
	logic [NBITS_W-1:0]  rem_q;
	logic [SYM_W-1:0]    pend_q;
	logic                pend_v_q;
	rsp_t                out_q;
	logic                out_v_q;

	logic [NODE_W-1:0]   rd_data;
	logic [NODE_AW-1:0]  rd_addr;
	logic                wr_en;
	logic [IDX_W-1:0]    child;
	logic [IDX_W-1:0]    child_c;
	logic                is_leaf;
	logic [IDX_W-1:0]    pos_next;
	logic                out_free;
	logic                out_load;
	logic                step;
	logic                req_take;
	logic [NBITS_W-1:0]  nbits;

	htwd_ram #(
		.WIDTH(NODE_W),
		.DEPTH(NODE_COUNT)
	) u_node_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(node_addr(req.node_index)),
		.wdata({req.left_child, req.right_child}),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	assign req_ready = (state_q == S_IDLE);
	assign req_take  = req_valid && req_ready;
	assign wr_en     = req_take && (req.req_type == REQ_LOAD)
		&& (req.node_index >= SYM_LIM) && (req.node_index <= ROOT_POS);
	assign nbits     = (req.valid_bits > NBITS_W'(BYTE_W)) ? NBITS_W'(BYTE_W) : req.valid_bits;

	// rd_data always holds the node at pos_q while walking
	assign child    = byte_q[BYTE_W-1] ? rd_data[IDX_W-1:0] : rd_data[NODE_W-1:IDX_W];
	assign child_c  = (child > ROOT_POS) ? ROOT_POS : child;
	assign is_leaf  = (child_c < SYM_LIM);
	assign pos_next = is_leaf ? ROOT_POS : child_c;
	assign out_free = !out_v_q || rsp_ready;
	assign step     = (state_q == S_WALK) && !(is_leaf && pend_v_q && !out_free);
	// output register takes a new beat this cycle
	assign out_load = (step && is_leaf && pend_v_q)
		|| ((state_q == S_FLUSH) && pend_v_q && out_free);
	// on a stall re-read the current node so rd_data stays valid
	assign rd_addr  = step ? node_addr(pos_next) : node_addr(pos_q);

	assign rsp_valid = out_v_q;
	assign rsp       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pos_q    <= ROOT_POS;
			byte_q   <= '0;
			rem_q    <= '0;
			pend_q   <= '0;
			pend_v_q <= 1'b0;
			out_q    <= '0;
			out_v_q  <= 1'b0;
		end else begin
			if (rsp_ready && !out_load) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_take) begin
						if (req.req_type == REQ_LOAD) begin
							pos_q <= ROOT_POS;
						end else if (nbits != '0) begin
							byte_q  <= req.packed_byte;
							rem_q   <= nbits;
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (step) begin
						pos_q  <= pos_next;
						byte_q <= {byte_q[BYTE_W-2:0], 1'b0};
						rem_q  <= rem_q - 1'b1;
						if (is_leaf) begin
							// a newer leaf means the held one was not last
							if (pend_v_q) begin
								out_q   <= '{symbol: pend_q, last_of_item: 1'b0};
								out_v_q <= 1'b1;
							end
							pend_q   <= child_c[SYM_W-1:0];
							pend_v_q <= 1'b1;
						end
						if (rem_q == NBITS_W'(1)) begin
							state_q <= S_FLUSH;
						end
					end
				end
				S_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_q    <= '{symbol: pend_q, last_of_item: 1'b1};
						out_v_q  <= 1'b1;
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[sv/htwd_ram.sv]
module htwd_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 255
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/htwd_checker.sv]
module htwd_checker
	import htwd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// a load beat never produces a result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.req_type == REQ_LOAD) |=> !$rose(rsp_valid))
		else $error("result appeared after a load beat");

	// a decode beat with bits to walk closes the input right after it is taken
	a_walk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.req_type == REQ_DECODE) && (req.valid_bits != '0)
		|=> !req_ready)
		else $error("input open while walking a byte");

	// an empty byte is finished at once
	a_empty_byte: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.req_type == REQ_DECODE) && (req.valid_bits == '0)
		|=> req_ready)
		else $error("empty byte held the input");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled result beat dropped or changed");

endmodule

bind huffman_tree_walk_decoder_core htwd_checker u_htwd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import htwd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_WAIT    = 14;
	localparam int SETTLE      = 40;
	localparam int TREE_MAX    = 64;
	localparam logic [IDX_W-1:0] ABOVE_ROOT = ROOT_POS + 1'b1;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	huffman_tree_walk_decoder_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	int cycle_count = 0;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// shadow of the node table and walk, updated on each accepted request beat
	logic [IDX_W-1:0] node_left  [SYMBOLS:ROOT_INDEX];
	logic [IDX_W-1:0] node_right [SYMBOLS:ROOT_INDEX];
	logic [IDX_W-1:0] walk_pos = ROOT_POS;
	rsp_t             symbols_due[$];

	// stimulus side: internal nodes whose children are all safe to walk into
	int live_nodes[$];

	int  err_count  = 0;
	int  items_sent = 0;
	bit  send_idle  = 1'b1;
	bit  recv_idle  = 1'b1;

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		err_count++;
	endtask

	task automatic walk_request(input req_t r);
		logic [IDX_W-1:0] pos_next;
		rsp_t             hit;
		int               nbits;
		int               found;
		if (r.req_type == REQ_LOAD) begin
			if (r.node_index >= SYM_LIM && r.node_index <= ROOT_POS) begin
				node_left[r.node_index]  = r.left_child;
				node_right[r.node_index] = r.right_child;
			end
			walk_pos = ROOT_POS;
		end else begin
			nbits = (r.valid_bits > 4'd8) ? 8 : int'(r.valid_bits);
			found = 0;
			for (int i = 0; i < nbits; i++) begin
				pos_next = r.packed_byte[BYTE_W-1-i] ? node_right[walk_pos]
				                                     : node_left[walk_pos];
				if (pos_next > ROOT_POS) begin
					walk_pos = ROOT_POS;
				end else if (pos_next < SYM_LIM) begin
					hit.symbol       = pos_next[SYM_W-1:0];
					hit.last_of_item = 1'b0;
					symbols_due.push_back(hit);
					found++;
					walk_pos = ROOT_POS;
				end else begin
					walk_pos = pos_next;
				end
			end
			if (found > 0)
				symbols_due[symbols_due.size()-1].last_of_item = 1'b1;
		end
	endtask

	// valid is held over from the previous beat when there is no gap
	task automatic send_beat(input req_t r);
		int gap;
		gap = send_idle ? $urandom_range(0, MAX_WAIT) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		walk_request(r);
		items_sent++;
	endtask

	function automatic req_t load_req(input int idx, input int lc, input int rc);
		req_t r;
		r.req_type    = REQ_LOAD;
		r.node_index  = IDX_W'(idx);
		r.left_child  = IDX_W'(lc);
		r.right_child = IDX_W'(rc);
		r.packed_byte = BYTE_W'($urandom);
		r.valid_bits  = NBITS_W'($urandom);
		return r;
	endfunction

	function automatic req_t decode_req(input int data, input int nbits);
		req_t r;
		r.req_type    = REQ_DECODE;
		r.node_index  = IDX_W'($urandom);
		r.left_child  = IDX_W'($urandom);
		r.right_child = IDX_W'($urandom);
		r.packed_byte = BYTE_W'(data);
		r.valid_bits  = NBITS_W'(nbits);
		return r;
	endfunction

	// leaf mostly, now and then a jump above the root or back into known nodes
	function automatic int pick_child(input int pool[$]);
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 16)
			return $urandom_range(0, SYMBOLS - 1);
		else if (sel < 18)
			return int'(ABOVE_ROOT);
		return pool[$urandom_range(0, pool.size() - 1)];
	endfunction

	task automatic send_random_decode();
		int sel;
		int nbits;
		sel = $urandom_range(0, 9);
		if (sel < 7)
			nbits = 8;
		else if (sel == 7)
			nbits = $urandom_range(1, 7);
		else if (sel == 8)
			nbits = $urandom_range(9, 15);
		else
			nbits = 0;
		send_beat(decode_req($urandom_range(0, 255), nbits));
	endtask

	// random tree rooted at ROOT_POS; every internal child is loaded in the same pass
	task automatic load_random_tree(input int n);
		int pool[$];
		int nodes[TREE_MAX];
		int kid_l[TREE_MAX];
		int kid_r[TREE_MAX];
		int order[TREE_MAX];
		int set_q[$];
		int k, tmp, p;
		for (int i = SYMBOLS; i < ROOT_INDEX; i++)
			pool.push_back(i);
		for (int j = 0; j < n - 1; j++) begin
			k = $urandom_range(j, pool.size() - 1);
			tmp = pool[j];
			pool[j] = pool[k];
			pool[k] = tmp;
		end
		nodes[0] = ROOT_INDEX;
		for (int j = 1; j < n; j++)
			nodes[j] = pool[j-1];
		for (int j = 0; j < n; j++) begin
			kid_l[j] = -1;
			kid_r[j] = -1;
			order[j] = j;
			set_q.push_back(nodes[j]);
		end
		// hang each new node off a free slot of an earlier one
		for (int j = 1; j < n; j++) begin
			p = $urandom_range(0, j - 1);
			while (kid_l[p] != -1 && kid_r[p] != -1)
				p = (p + 1) % j;
			if (kid_l[p] == -1 && (kid_r[p] != -1 || $urandom_range(0, 1)))
				kid_l[p] = nodes[j];
			else
				kid_r[p] = nodes[j];
		end
		for (int j = 0; j < n; j++) begin
			if (kid_l[j] == -1) kid_l[j] = pick_child(set_q);
			if (kid_r[j] == -1) kid_r[j] = pick_child(set_q);
		end
		for (int j = n - 1; j > 0; j--) begin
			k = $urandom_range(0, j);
			tmp = order[j];
			order[j] = order[k];
			order[k] = tmp;
		end
		for (int j = 0; j < n; j++) begin
			send_beat(load_req(nodes[order[j]], kid_l[order[j]], kid_r[order[j]]));
			live_nodes.push_back(nodes[order[j]]);
		end
	endtask

	task automatic test_edge_cases();
		send_idle = 1'b1;
		recv_idle = 1'b1;
		// root: symbol 0 on the left; node 256: symbol 255 left, above-root right
		send_beat(load_req(ROOT_INDEX, 0, SYMBOLS));
		send_beat(load_req(SYMBOLS, SYMBOLS - 1, int'(ABOVE_ROOT)));
		live_nodes.push_back(ROOT_INDEX);
		live_nodes.push_back(SYMBOLS);
		// out of range loads must leave the table alone
		send_beat(load_req(0, 1, 2));
		send_beat(load_req(SYMBOLS - 1, int'(ABOVE_ROOT), int'(ABOVE_ROOT)));
		send_beat(load_req(int'(ABOVE_ROOT), 3, 4));
		send_beat(decode_req(8'h00, 0));
		send_beat(decode_req(8'h00, 8));
		send_beat(decode_req(8'hff, 8));
		send_beat(decode_req(8'haa, 8));
		// ends mid-walk at node 256, next byte finishes it
		send_beat(decode_req(8'h55, 8));
		send_beat(decode_req(8'h00, 1));
		send_beat(decode_req(8'h80, 15));
		send_beat(decode_req(8'hc0, 9));
		send_beat(decode_req(8'h7f, 7));
		// a load in the middle of a walk sends it back to the root
		send_beat(decode_req(8'h80, 1));
		send_beat(load_req(SYMBOLS, SYMBOLS - 1, int'(ABOVE_ROOT)));
		send_beat(decode_req(8'h00, 1));
		send_idle = 1'b0;
		recv_idle = 1'b0;
		send_beat(decode_req(8'h00, 8));
		send_beat(decode_req(8'h2a, 8));
	endtask

	task automatic test_random_trees(input int item_goal);
		int n;
		int reps;
		while (items_sent < item_goal) begin
			send_idle = ($urandom_range(0, 3) != 0);
			recv_idle = ($urandom_range(0, 3) != 0);
			n = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 12);
			load_random_tree(n);
			reps = $urandom_range(8, 20);
			repeat (reps) send_random_decode();
		end
	endtask

	task automatic test_reload_during_decode(input int item_goal);
		int sel;
		int idx;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		load_random_tree($urandom_range(6, 16));
		while (items_sent < item_goal) begin
			if ($urandom_range(0, 29) == 0) begin
				send_idle = ~send_idle;
				recv_idle = ($urandom_range(0, 1) != 0);
			end
			sel = $urandom_range(0, 19);
			if (sel < 14) begin
				send_random_decode();
			end else if (sel < 17) begin
				idx = $urandom_range(SYMBOLS, ROOT_INDEX);
				send_beat(load_req(idx, pick_child(live_nodes), pick_child(live_nodes)));
				live_nodes.push_back(idx);
			end else begin
				idx = ($urandom_range(0, 3) == 0) ? int'(ABOVE_ROOT) : $urandom_range(0, SYMBOLS - 1);
				send_beat(load_req(idx, $urandom_range(0, 511), $urandom_range(0, 511)));
			end
		end
	endtask

	// receiver: stalls at random if recv_idle, checks each beat against the oldest symbol due
	initial begin
		rsp_t want;
		int   gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = recv_idle ? $urandom_range(0, MAX_WAIT) : 0;
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
			if (symbols_due.size() == 0) begin
				report_mismatch($sformatf("unexpected symbol %0d last %0b",
					rsp.symbol, rsp.last_of_item));
			end else begin
				want = symbols_due.pop_front();
				if (rsp.symbol !== want.symbol)
					report_mismatch($sformatf("symbol got %0d want %0d",
						rsp.symbol, want.symbol));
				if (rsp.last_of_item !== want.last_of_item)
					report_mismatch($sformatf("last_of_item got %0b want %0b (symbol %0d)",
						rsp.last_of_item, want.last_of_item, want.symbol));
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edge_cases();
		test_random_trees(220);
		test_reload_during_decode(330);
		req_valid <= 1'b0;
		while (symbols_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (err_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
